FILE: hdl/radar_report_deframer_presence_top_assert.svh
// Assertion macros for the radar report deframer checker.
// No dependencies; included by the checker file.
`ifndef RADAR_REPORT_DEFRAMER_PRESENCE_TOP_ASSERT_SVH
`define RADAR_REPORT_DEFRAMER_PRESENCE_TOP_ASSERT_SVH

// Clocked assertion, muted while reset is asserted.
`define RRDP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked through reset.
`define RRDP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/rrdp_pkg.sv
// Shared types and constants for the radar report deframer.
// No dependencies.
package rrdp_pkg;

  localparam logic [7:0] HDR0 = 8'hF4;
  localparam logic [7:0] HDR1 = 8'hF3;
  localparam logic [7:0] HDR2 = 8'hF2;
  localparam logic [7:0] HDR3 = 8'hF1;
  localparam logic [7:0] FRAME_LEN_LO = 8'h0D;
  localparam logic [7:0] FRAME_LEN_HI = 8'h00;
  localparam logic [7:0] TARGET_HEAD = 8'hAA;

  localparam int PAYLOAD_BYTES = 13;
  localparam int TRAIL_BYTES = 4;
  localparam int IDX_W = $clog2(PAYLOAD_BYTES);

  localparam logic [IDX_W-1:0] PAYLOAD_LAST = IDX_W'(PAYLOAD_BYTES - 1);
  localparam logic [IDX_W-1:0] TRAIL_LAST = IDX_W'(TRAIL_BYTES - 1);

  localparam logic [15:0] PRESENCE_LIMIT_RST = 16'd100;
  localparam logic [7:0] MIN_STATE_RST = 8'd2;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PRESENCE_LIMIT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIN_STATE = 8'd1;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_HDR1,
    ST_HDR2,
    ST_HDR3,
    ST_LEN_LO,
    ST_LEN_HI,
    ST_PAYLOAD,
    ST_TRAIL
  } parse_state_t;

  typedef struct packed {
    logic [7:0] report_type;
    logic [7:0] head_byte;
    logic [7:0] tgt_state;
    logic [15:0] moving_distance_cm;
    logic [7:0] moving_energy;
    logic [15:0] still_distance_cm;
    logic [7:0] still_energy;
    logic [15:0] detect_distance_cm;
  } report_fields_t;

endpackage

FILE: hdl/rrdp_parser.sv
// Byte register, frame sync state machine and payload capture.
// Depends on rrdp_pkg.
module rrdp_parser (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_rx_byte,
  output logic                    emit_valid,
  input  logic                    emit_ready,
  output rrdp_pkg::report_fields_t fields
);
  import rrdp_pkg::*;

  logic byte_valid_r;
  logic [7:0] byte_r;
  parse_state_t state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [7:0] len_lo_r;
  logic [7:0] payload_r [PAYLOAD_BYTES];
  logic adv;
  logic emit;
  logic store_we;

  // byte retires unless it closes a frame and the result slot is full
  assign adv = byte_valid_r && (!emit || emit_ready);
  assign in_ready = !byte_valid_r || adv;
  assign emit_valid = byte_valid_r && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_valid_r <= 1'b0;
    end else if (in_ready) begin
      byte_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    case (state_r)
      ST_HUNT: state_nxt = (byte_r == HDR0) ? ST_HDR1 : ST_HUNT;
      ST_HDR1: begin
        if (byte_r == HDR1) state_nxt = ST_HDR2;
        else state_nxt = (byte_r == HDR0) ? ST_HDR1 : ST_HUNT;
      end
      ST_HDR2: begin
        if (byte_r == HDR2) state_nxt = ST_HDR3;
        else state_nxt = (byte_r == HDR0) ? ST_HDR1 : ST_HUNT;
      end
      ST_HDR3: begin
        if (byte_r == HDR3) state_nxt = ST_LEN_LO;
        else state_nxt = (byte_r == HDR0) ? ST_HDR1 : ST_HUNT;
      end
      ST_LEN_LO: state_nxt = ST_LEN_HI;
      ST_LEN_HI: begin
        cnt_nxt = '0;
        state_nxt = (len_lo_r == FRAME_LEN_LO && byte_r == FRAME_LEN_HI) ?
                    ST_PAYLOAD : ST_HUNT;
      end
      ST_PAYLOAD: begin
        if (cnt_r == PAYLOAD_LAST) begin
          cnt_nxt = '0;
          state_nxt = ST_TRAIL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_TRAIL: begin
        if (cnt_r == TRAIL_LAST) begin
          state_nxt = ST_HUNT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: state_nxt = ST_HUNT;
    endcase
  end

  // outputs
  always_comb begin
    emit = 1'b0;
    store_we = 1'b0;
    case (state_r)
      ST_PAYLOAD: store_we = 1'b1;
      ST_TRAIL: emit = (cnt_r == TRAIL_LAST);
      default: begin
        emit = 1'b0;
        store_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
      cnt_r <= '0;
      len_lo_r <= '0;
    end else if (adv) begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      if (state_r == ST_LEN_LO) begin
        len_lo_r <= byte_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && store_we) begin
      payload_r[cnt_r] <= byte_r;
    end
  end

  assign fields.report_type = payload_r[0];
  assign fields.head_byte = payload_r[1];
  assign fields.tgt_state = payload_r[2];
  assign fields.moving_distance_cm = {payload_r[4], payload_r[3]};
  assign fields.moving_energy = payload_r[5];
  assign fields.still_distance_cm = {payload_r[7], payload_r[6]};
  assign fields.still_energy = payload_r[8];
  assign fields.detect_distance_cm = {payload_r[10], payload_r[9]};

endmodule

FILE: hdl/rrdp_report.sv
// Presence decision and result register.
// Depends on rrdp_pkg.
module rrdp_report (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     emit_valid,
  output logic                     emit_ready,
  input  rrdp_pkg::report_fields_t fields,
  input  logic [15:0]              presence_limit_cm,
  input  logic [7:0]               min_tgt_state,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [7:0]               out_report_type,
  output logic [7:0]               out_head_byte,
  output logic [7:0]               out_tgt_state,
  output logic [15:0]              out_moving_distance_cm,
  output logic [7:0]               out_moving_energy,
  output logic [15:0]              out_still_distance_cm,
  output logic [7:0]               out_still_energy,
  output logic [15:0]              out_detect_distance_cm,
  output logic                     out_presence
);
  import rrdp_pkg::*;

  logic out_valid_r;
  report_fields_t rpt_r;
  logic presence_r;
  logic presence_nxt;
  logic load;

  assign emit_ready = !out_valid_r || out_ready;
  assign load = emit_valid && emit_ready;

  assign presence_nxt = (fields.head_byte == TARGET_HEAD) &&
                        (fields.tgt_state >= min_tgt_state) &&
                        (fields.moving_distance_cm < presence_limit_cm);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_ready) begin
      out_valid_r <= emit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rpt_r <= fields;
      presence_r <= presence_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_report_type = rpt_r.report_type;
  assign out_head_byte = rpt_r.head_byte;
  assign out_tgt_state = rpt_r.tgt_state;
  assign out_moving_distance_cm = rpt_r.moving_distance_cm;
  assign out_moving_energy = rpt_r.moving_energy;
  assign out_still_distance_cm = rpt_r.still_distance_cm;
  assign out_still_energy = rpt_r.still_energy;
  assign out_detect_distance_cm = rpt_r.detect_distance_cm;
  assign out_presence = presence_r;

endmodule

FILE: hdl/radar_report_deframer_presence_top.sv
// Radar report deframer top: config registers, parser and result stage.
// Depends on rrdp_pkg, rrdp_parser, rrdp_report.
// Throughput: one byte per cycle unless a stalled result holds the closing byte; a byte register feeds the parser.
// The last trailing byte passes the byte register and then the result register before its report shows.
// A stalled result holds the closing byte in the byte register and stops input until the result is taken.
// Reset (sync, active low) returns to hunting and loads limit 100, min state 2.
module radar_report_deframer_presence_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_report_type,
  output logic [7:0]                    out_head_byte,
  output logic [7:0]                    out_tgt_state,
  output logic [15:0]                   out_moving_distance_cm,
  output logic [7:0]                    out_moving_energy,
  output logic [15:0]                   out_still_distance_cm,
  output logic [7:0]                    out_still_energy,
  output logic [15:0]                   out_detect_distance_cm,
  output logic                          out_presence,
  input  logic                          cfg_we,
  input  logic [rrdp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_wdata
);
  import rrdp_pkg::*;

  logic [15:0] presence_limit_r;
  logic [7:0] min_state_r;
  logic emit_valid;
  logic emit_ready;
  report_fields_t fields;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      presence_limit_r <= PRESENCE_LIMIT_RST;
      min_state_r <= MIN_STATE_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_IDX_PRESENCE_LIMIT) begin
        presence_limit_r <= cfg_wdata;
      end
      if (cfg_index == CFG_IDX_MIN_STATE) begin
        min_state_r <= cfg_wdata[7:0];
      end
    end
  end

  rrdp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .emit_valid (emit_valid),
    .emit_ready (emit_ready),
    .fields     (fields)
  );

  rrdp_report u_report (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .emit_valid             (emit_valid),
    .emit_ready             (emit_ready),
    .fields                 (fields),
    .presence_limit_cm      (presence_limit_r),
    .min_tgt_state          (min_state_r),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_report_type        (out_report_type),
    .out_head_byte          (out_head_byte),
    .out_tgt_state          (out_tgt_state),
    .out_moving_distance_cm (out_moving_distance_cm),
    .out_moving_energy      (out_moving_energy),
    .out_still_distance_cm  (out_still_distance_cm),
    .out_still_energy       (out_still_energy),
    .out_detect_distance_cm (out_detect_distance_cm),
    .out_presence           (out_presence)
  );

endmodule

FILE: hdl/rrdp_checker.sv
// Port-level checks for the radar report deframer, bound to the top level.
// Depends on radar_report_deframer_presence_top_assert.svh and rrdp_pkg.
`include "radar_report_deframer_presence_top_assert.svh"

module rrdp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_head_byte,
  input logic [7:0] out_report_type,
  input logic       out_presence
);
  import rrdp_pkg::*;

  // reset leaves no report pending and the byte register open
  `RRDP_ASSERT_RST(a_reset_empty, !rst_n |=> (!out_valid && in_ready), "not empty after reset")

  // a new report comes only from an accepted byte that passed the byte register and the result register
  `RRDP_ASSERT(a_rose_src, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "report from nowhere")

  // presence requires a target report head
  `RRDP_ASSERT(a_pres_head, (out_valid && out_presence) |-> (out_head_byte == TARGET_HEAD), "presence without head")

  `RRDP_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_report_type)), "stalled beat changed")

endmodule

bind radar_report_deframer_presence_top rrdp_checker u_rrdp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_head_byte   (out_head_byte),
  .out_report_type (out_report_type),
  .out_presence    (out_presence)
);
